>>> rtl/bfh_pkg.sv
// Shared types and constants for the three-slice-hash Bloom filter.
// Holds the request, response and internal command formats; no dependencies.
package bfh_pkg;

	localparam int FILTER_BITS = 1024;
	localparam int HASH_COUNT  = 3;
	localparam int WORD_W      = 32;
	localparam int WORD_COUNT  = FILTER_BITS / WORD_W;
	localparam int IDX_W       = $clog2(FILTER_BITS);
	localparam int WADDR_W     = $clog2(WORD_COUNT);
	localparam int POS_W       = $clog2(WORD_W);
	localparam int PROBE_W     = $clog2(HASH_COUNT);
	localparam int CNT_W       = 11;
	localparam int ELEM_W      = 16;
	localparam int POP_W       = 6;
	localparam logic [ELEM_W-1:0] ELEM_MAX = 16'hffff;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_TEST  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [23:0]        key_head;
		logic               key_short;
		logic [WADDR_W-1:0] word_index;
		logic [WORD_W-1:0]  word_data;
	} req_t;

	typedef struct packed {
		logic              present;
		logic [WORD_W-1:0] word_out;
		logic [CNT_W-1:0]  set_bit_count;
		logic [ELEM_W-1:0] elements_added;
	} rsp_t;

	typedef struct packed {
		op_t                                op;
		logic [HASH_COUNT-1:0][IDX_W-1:0]   idx;
		logic [WADDR_W-1:0]                 word_index;
		logic [WORD_W-1:0]                  word_data;
	} cmd_t;

endpackage

>>> rtl/bfh_front.sv
// Front end of the Bloom filter: takes request beats and turns them into commands.
// The three bit indices are fixed key-head bits, zero for a short key. Depends on bfh_pkg.
module bfh_front (
	input  logic          req_valid,
	output logic          req_stall,
	input  bfh_pkg::req_t req,
	output logic          push_valid,
	input  logic          push_full,
	output bfh_pkg::cmd_t push_cmd
);

	logic [bfh_pkg::IDX_W-1:0] h0, h1, h2;

	always_comb begin
		h0 = req.key_head[23:14];
		h1 = req.key_head[13:4];
		h2 = {req.key_head[18:16], 1'b0, req.key_head[14:9]};
		if (req.key_short) begin
			h0 = '0;
			h1 = '0;
			h2 = '0;
		end
	end

	always_comb begin
		push_cmd            = '0;
		push_cmd.op         = req.op;
		push_cmd.word_index = req.word_index;
		push_cmd.word_data  = req.word_data;
		if (req.op == bfh_pkg::OP_ADD || req.op == bfh_pkg::OP_TEST) begin
			push_cmd.idx[0] = h0;
			push_cmd.idx[1] = h1;
			push_cmd.idx[2] = h2;
		end
	end

	assign push_valid = req_valid;
	assign req_stall  = push_full;

endmodule

>>> rtl/bfh_queue.sv
// Two-entry command queue between the front end and the execution unit.
// Depends on bfh_pkg for the command format.
module bfh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_full,
	input  bfh_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output bfh_pkg::cmd_t pop_cmd
);

	bfh_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign push_full = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign do_push   = push_valid && !push_full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/bfh_back.sv
// Execution unit of the Bloom filter: the 32 x 32 filter memory, the counters
// and the response register. Runs one command at a time. Depends on bfh_pkg.
module bfh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  bfh_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bfh_pkg::rsp_t rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EX,
		ST_SUM,
		ST_DONE
	} state_t;

	function automatic logic [bfh_pkg::POP_W-1:0] pop32(input logic [bfh_pkg::WORD_W-1:0] v);
		logic [bfh_pkg::POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + bfh_pkg::POP_W'(v[4*i]) + bfh_pkg::POP_W'(v[4*i+1])
			      + bfh_pkg::POP_W'(v[4*i+2]) + bfh_pkg::POP_W'(v[4*i+3]);
		end
		return n;
	endfunction

	state_t                              state_q;
	bfh_pkg::cmd_t                       cmd_q;
	logic [bfh_pkg::PROBE_W-1:0]         probe_q;
	logic                                present_q;
	logic [bfh_pkg::WORD_W-1:0]          word_out_q;
	logic [bfh_pkg::POP_W-1:0]           pop_old_q;
	logic [bfh_pkg::POP_W-1:0]           pop_new_q;
	logic [bfh_pkg::CNT_W-1:0]           bit_total_q;
	logic [bfh_pkg::ELEM_W-1:0]          elem_total_q;
	logic                                rsp_valid_q;
	bfh_pkg::rsp_t                       rsp_q;

	logic [bfh_pkg::WORD_W-1:0]          mem_q [bfh_pkg::WORD_COUNT];
	logic [bfh_pkg::WORD_COUNT-1:0]      row_valid_q;
	logic [bfh_pkg::WORD_W-1:0]          rd_data_q;
	logic                                rd_valid_q;

	logic                                is_key_op;
	logic [bfh_pkg::IDX_W-1:0]           probe_idx;
	logic [bfh_pkg::WADDR_W-1:0]         addr;
	logic [bfh_pkg::POS_W-1:0]           pos;
	logic [bfh_pkg::WORD_W-1:0]          word_cur;
	logic                                bit_cur;
	logic                                mem_we;
	logic [bfh_pkg::WORD_W-1:0]          mem_wdata;
	logic                                rsp_free;
	logic [bfh_pkg::ELEM_W-1:0]          elem_next;

	assign is_key_op = (cmd_q.op == bfh_pkg::OP_ADD) || (cmd_q.op == bfh_pkg::OP_TEST);
	assign probe_idx = cmd_q.idx[probe_q];
	assign addr      = is_key_op ? probe_idx[bfh_pkg::IDX_W-1:bfh_pkg::POS_W] : cmd_q.word_index;
	assign pos       = probe_idx[bfh_pkg::POS_W-1:0];
	assign word_cur  = rd_valid_q ? rd_data_q : '0;
	assign bit_cur   = word_cur[pos];
	assign mem_we    = (state_q == ST_EX) &&
	                   (((cmd_q.op == bfh_pkg::OP_ADD) && !bit_cur) ||
	                    (cmd_q.op == bfh_pkg::OP_WRITE));
	assign mem_wdata = (cmd_q.op == bfh_pkg::OP_WRITE) ? cmd_q.word_data
	                   : (word_cur | (bfh_pkg::WORD_W'(1) << pos));
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign elem_next = ((cmd_q.op == bfh_pkg::OP_ADD) && (elem_total_q != bfh_pkg::ELEM_MAX))
	                   ? elem_total_q + 1'b1 : elem_total_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr] <= mem_wdata;
		end
		if (state_q == ST_RD) begin
			rd_data_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				row_valid_q[addr] <= 1'b1;
			end
			if (state_q == ST_RD) begin
				rd_valid_q <= row_valid_q[addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= '0;
			probe_q      <= '0;
			present_q    <= 1'b0;
			word_out_q   <= '0;
			pop_old_q    <= '0;
			pop_new_q    <= '0;
			bit_total_q  <= '0;
			elem_total_q <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !((state_q == ST_DONE) && rsp_free)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q      <= cmd;
						probe_q    <= '0;
						present_q  <= 1'b1;
						word_out_q <= '0;
						state_q    <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EX;
				end
				ST_EX: begin
					case (cmd_q.op)
						bfh_pkg::OP_ADD, bfh_pkg::OP_TEST: begin
							if (!bit_cur) begin
								if (cmd_q.op == bfh_pkg::OP_ADD) begin
									bit_total_q <= bit_total_q + 1'b1;
								end else begin
									present_q <= 1'b0;
								end
							end
							if (probe_q == bfh_pkg::PROBE_W'(bfh_pkg::HASH_COUNT - 1)) begin
								state_q <= ST_DONE;
							end else begin
								probe_q <= probe_q + 1'b1;
								state_q <= ST_RD;
							end
						end
						bfh_pkg::OP_WRITE: begin
							pop_old_q <= pop32(word_cur);
							pop_new_q <= pop32(cmd_q.word_data);
							state_q   <= ST_SUM;
						end
						default: begin
							word_out_q <= word_cur;
							state_q    <= ST_DONE;
						end
					endcase
				end
				ST_SUM: begin
					bit_total_q <= bit_total_q - bfh_pkg::CNT_W'(pop_old_q)
					               + bfh_pkg::CNT_W'(pop_new_q);
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						elem_total_q         <= elem_next;
						rsp_valid_q          <= 1'b1;
						rsp_q.present        <= (cmd_q.op == bfh_pkg::OP_TEST) && present_q;
						rsp_q.word_out       <= word_out_q;
						rsp_q.set_bit_count  <= bit_total_q;
						rsp_q.elements_added <= elem_next;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_bit_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_total_q <= bfh_pkg::CNT_W'(bfh_pkg::FILTER_BITS))
		else $error("set bit count exceeds filter size");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		probe_q <= bfh_pkg::PROBE_W'(bfh_pkg::HASH_COUNT - 1))
		else $error("probe counter out of range");

	a_ex_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EX) |-> ($past(state_q) == ST_RD))
		else $error("execute step without a preceding memory read");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("response raised outside the completion step");

	a_elem_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		elem_total_q >= $past(elem_total_q))
		else $error("element count decreased");

endmodule

>>> rtl/bloom_filter_three_slice_hash.sv
// An add or test beat runs the read and execute steps once per probe, then completion; a write
// runs read, execute, sum and completion; a read runs read, execute and completion. Each beat is
// finished before the next is taken; the single memory read port serves the three probes in turn.
// A two-entry queue lets request beats be taken while a response waits to be taken.
// Reset (arst_n low, asynchronous) clears the filter through per-word valid bits and both counters.
module bloom_filter_three_slice_hash (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bfh_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bfh_pkg::rsp_t rsp
);

	logic          push_valid;
	logic          push_full;
	bfh_pkg::cmd_t push_cmd;
	logic          pop_valid;
	logic          pop;
	bfh_pkg::cmd_t pop_cmd;

	bfh_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_cmd   (push_cmd)
	);

	bfh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	bfh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_pop   (pop),
		.cmd       (pop_cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
